### hdl/note_sequence_triangle_synth_core_defines.svh
// Assertion macros shared by the tone sample generator RTL.
`ifndef NOTE_SEQUENCE_TRIANGLE_SYNTH_CORE_DEFINES_SVH
`define NOTE_SEQUENCE_TRIANGLE_SYNTH_CORE_DEFINES_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define NSTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsts: same-cycle check failed");

// Checks a condition that must hold in the cycle after its trigger.
`define NSTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsts: next-cycle check failed");

`endif

### hdl/nsts_pkg.sv
// Constants, tables and helper functions of the tone sample generator.
package nsts_pkg;

  // Note table geometry.
  localparam int NOTE_SLOTS = 16;
  localparam int SLOT_W     = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
  localparam int FREQ_W     = 16;
  localparam int SAMPLE_W   = 15;

  // Item kinds.
  localparam logic ACT_GENERATE = 1'b0;
  localparam logic ACT_WRITE    = 1'b1;

  // Waveform constants.
  localparam int NOTE_LEN   = 8000;
  localparam int PHASE_SPAN = 32000;
  localparam int QUARTER    = 8000;
  localparam int HALF       = 16000;
  localparam int THREE_Q    = 24000;
  localparam int PEAK       = 9000;
  localparam int ENV_FULL   = 256;
  localparam int REL_START  = NOTE_LEN - 257;

  // Reciprocal of 125 for frame / 8000 = (frame >> 6) / 125, exact for 26-bit inputs.
  localparam logic [26:0] RECIP_NOTE_M  = 27'd68719477;
  localparam int          RECIP_NOTE_SH = 33;
  // Reciprocal of 125 for x / 32000 = (x >> 8) / 125, exact for 21-bit inputs.
  localparam logic [21:0] RECIP_PHASE_M  = 22'd2147484;
  localparam int          RECIP_PHASE_SH = 28;

  // Result queue behind the pipeline.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  localparam logic [15:0] RESET_TUNE [16] = '{
    16'd262, 16'd330, 16'd392, 16'd523,
    16'd440, 16'd349, 16'd392, 16'd294,
    16'd330, 16'd494, 16'd392, 16'd262,
    16'd294, 16'd349, 16'd440, 16'd0
  };

  // Frequency a slot holds after reset.
  function automatic logic [FREQ_W-1:0] reset_freq(input logic [8:0] idx);
    logic [FREQ_W-1:0] f;
    f = '0;
    if (idx < 9'd16) begin
      f = RESET_TUNE[idx[3:0]];
    end
    return f;
  endfunction

endpackage

### hdl/nsts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nsts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/note_sequence_triangle_synth_core.sv
// Top level of the tone sequencer sample generator.
//
// Usage: the input channel (in_valid/in_ready) carries one item per handshake.
// An item with action set to generate brings an absolute frame number and yields
// exactly one signed triangle sample on the output channel (out_valid/out_ready).
// An item with action set to write stores note_frequency in note table slot
// note_slot and yields nothing. Results leave in the order their items came in.
// A sample passes through pipeline stages A to F and then the result queue before
// it is presented on out_valid. Throughput: one item per cycle while credit remains,
// sustained by a six-stage pipeline around the note table memory, whose single read
// port is used once per generate item.
// Up to eight generate items may be outstanding; a result queue of eight entries
// sits behind the pipeline, so when the receiver stalls the block keeps taking
// items until that credit runs out and then drops in_ready. in_ready never
// depends combinationally on out_ready.
// Reset (rst, synchronous) empties the pipeline and the queue and returns every
// note table slot to its power-on tune; the block is ready in the first cycle
// after reset.
module note_sequence_triangle_synth_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic [31:0]                           frame_number,
  input  logic [3:0]                            note_slot,
  input  logic [nsts_pkg::FREQ_W-1:0]           note_frequency,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [nsts_pkg::SAMPLE_W-1:0]  sample_value
);

`include "note_sequence_triangle_synth_core_defines.svh"

  // Handshake decode.
  logic in_acc;
  logic gen_acc;
  logic wr_acc;
  logic pop;

  // Credit count: generate items accepted whose results are not yet taken.
  logic [3:0] cnt;

  // Stage A: frame divided by the note length.
  logic [52:0] q_prod;
  logic        a_valid;
  logic [31:0] a_frame;
  logic [19:0] a_q;

  // Stage B: position in note, table read in flight.
  logic [31:0]                      pos_full;
  logic [19:0]                      slot_mod;
  logic [nsts_pkg::SLOT_W-1:0]      rd_addr;
  logic [nsts_pkg::FREQ_W-1:0]      ram_rd;
  logic                             b_valid;
  logic [12:0]                      b_pos;
  logic [nsts_pkg::SLOT_W-1:0]      b_slot;
  logic                             b_written;

  // Note table write side and slot valid bits.
  logic [8:0]                       wr_slot_wide;
  logic                             ram_we;
  logic [nsts_pkg::NOTE_SLOTS-1:0]  slot_vld;

  // Stage C: frequency times position, envelope.
  logic [nsts_pkg::FREQ_W-1:0] freq;
  logic [8:0]                  env;
  logic                        c_valid;
  logic [28:0]                 c_prod;
  logic [8:0]                  c_env;
  logic                        c_zero;

  // Stage D: quotient of the product by the phase span.
  logic [42:0] ph_prod;
  logic        d_valid;
  logic [28:0] d_prod;
  logic [14:0] d_q2;
  logic [8:0]  d_env;
  logic        d_zero;

  // Stage E: phase and triangle value.
  logic [28:0]        ph_full;
  logic [14:0]        phase;
  logic [12:0]        seg_x;
  logic               rising;
  logic [16:0]        rise_w;
  logic [14:0]        rise;
  logic signed [15:0] tri_w;
  logic               e_valid;
  logic signed [14:0] e_tri;
  logic [8:0]         e_env;
  logic               e_zero;

  // Stage F: enveloped product.
  logic               f_valid;
  logic signed [24:0] f_mult;
  logic               f_zero;

  // Final scaling and result queue.
  logic signed [24:0]                   adj;
  logic signed [24:0]                   scaled;
  logic signed [nsts_pkg::SAMPLE_W-1:0] result;
  logic [nsts_pkg::SAMPLE_W-1:0]        fifo_mem [nsts_pkg::FIFO_DEPTH];
  logic [nsts_pkg::FIFO_AW-1:0]         wr_ptr;
  logic [nsts_pkg::FIFO_AW-1:0]         rd_ptr;
  logic [3:0]                           fifo_cnt;

  // The credit limit equals the queue depth, so the queue can never overflow
  // even when every pipeline stage holds an item.
  assign in_ready = (cnt < 4'(nsts_pkg::FIFO_DEPTH));
  assign in_acc   = in_valid && in_ready;
  assign gen_acc  = in_acc && (action == nsts_pkg::ACT_GENERATE);
  assign wr_acc   = in_acc && (action == nsts_pkg::ACT_WRITE);
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 4'(gen_acc) - 4'(pop);
    end
  end

  // Stage A: frame / 8000 as (frame >> 6) times a reciprocal of 125.
  assign q_prod = 53'(frame_number[31:6]) * 53'(nsts_pkg::RECIP_NOTE_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= gen_acc;
    end
    a_frame <= frame_number;
    a_q     <= q_prod[nsts_pkg::RECIP_NOTE_SH +: 20];
  end

  // Stage B: remainder gives the position, the quotient picks the slot.
  assign pos_full = a_frame - (32'(a_q) * 32'(nsts_pkg::NOTE_LEN));
  assign slot_mod = a_q % 20'(nsts_pkg::NOTE_SLOTS);
  assign rd_addr  = slot_mod[nsts_pkg::SLOT_W-1:0];

  // Writes land in the RAM at their accept edge. The RAM reads old data on a
  // same-entry collision, which is exactly the order of the items: a write
  // accepted at the read edge of an earlier generate item comes after it.
  assign wr_slot_wide = 9'(note_slot);
  assign ram_we       = wr_acc && (wr_slot_wide < 9'(nsts_pkg::NOTE_SLOTS));

  nsts_ram #(
    .WIDTH (nsts_pkg::FREQ_W),
    .DEPTH (nsts_pkg::NOTE_SLOTS)
  ) u_note_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_slot_wide[nsts_pkg::SLOT_W-1:0]),
    .wr_data (note_frequency),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // A slot never written since reset reads as its power-on tune value.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (ram_we) begin
      slot_vld[wr_slot_wide[nsts_pkg::SLOT_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_pos     <= pos_full[12:0];
    b_slot    <= rd_addr;
    b_written <= slot_vld[rd_addr];
  end

  // Stage C: frequency lookup, phase product and envelope.
  assign freq = b_written ? ram_rd : nsts_pkg::reset_freq(9'(b_slot));

  always_comb begin
    priority if (b_pos < 13'(nsts_pkg::ENV_FULL)) begin
      env = b_pos[8:0];
    end else if (b_pos > 13'(nsts_pkg::REL_START)) begin
      env = 9'(13'(nsts_pkg::NOTE_LEN - 1) - b_pos);
    end else begin
      env = 9'(nsts_pkg::ENV_FULL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_prod <= 29'(b_pos) * 29'(freq);
    c_env  <= env;
    c_zero <= (freq == '0);
  end

  // Stage D: product / 32000 as (product >> 8) times a reciprocal of 125.
  assign ph_prod = 43'(c_prod[28:8]) * 43'(nsts_pkg::RECIP_PHASE_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_prod <= c_prod;
    d_q2   <= ph_prod[nsts_pkg::RECIP_PHASE_SH +: 15];
    d_env  <= c_env;
    d_zero <= c_zero;
  end

  // Stage E: phase within the span, then the triangle. Slope 18000/8000 is 9/4.
  assign ph_full = d_prod - (29'(d_q2) * 29'(nsts_pkg::PHASE_SPAN));
  assign phase   = ph_full[14:0];

  always_comb begin
    priority if (phase < 15'(nsts_pkg::QUARTER)) begin
      seg_x  = phase[12:0];
      rising = 1'b1;
    end else if (phase < 15'(nsts_pkg::HALF)) begin
      seg_x  = 13'(phase - 15'(nsts_pkg::QUARTER));
      rising = 1'b0;
    end else if (phase < 15'(nsts_pkg::THREE_Q)) begin
      seg_x  = 13'(phase - 15'(nsts_pkg::HALF));
      rising = 1'b1;
    end else begin
      seg_x  = 13'(phase - 15'(nsts_pkg::THREE_Q));
      rising = 1'b0;
    end
  end

  assign rise_w = 17'(seg_x) * 17'd9;
  assign rise   = rise_w[16:2];
  assign tri_w  = rising ? ($signed({1'b0, rise}) - 16'(nsts_pkg::PEAK))
                         : (16'(nsts_pkg::PEAK) - $signed({1'b0, rise}));

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
    e_tri  <= tri_w[14:0];
    e_env  <= d_env;
    e_zero <= d_zero;
  end

  // Stage F: apply the envelope.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
    f_mult <= 25'(e_tri) * $signed({16'b0, e_env});
    f_zero <= e_zero;
  end

  // Divide by 256 rounding toward zero: bias negative values before the shift.
  assign adj    = f_mult + ((f_mult < 0) ? 25'sd255 : 25'sd0);
  assign scaled = adj >>> 8;
  assign result = f_zero ? '0 : scaled[nsts_pkg::SAMPLE_W-1:0];

  // Result queue.
  always_ff @(posedge clk) begin
    if (f_valid) begin
      fifo_mem[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (f_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + 4'(f_valid) - 4'(pop);
    end
  end

  assign out_valid    = (fifo_cnt != '0);
  assign sample_value = fifo_mem[rd_ptr];

  // The credit count bounds everything queued behind the pipeline.
  `NSTS_ASSERT_NOW(a_credit_bound, 1'b1, cnt <= 4'(nsts_pkg::FIFO_DEPTH))
  `NSTS_ASSERT_NOW(a_queue_within_credit, 1'b1, fifo_cnt <= cnt)
  // A write item never enters the sample pipeline.
  `NSTS_ASSERT_NEXT(a_write_no_sample, wr_acc, !a_valid)
  // A taken result with no new generate item releases exactly one credit.
  `NSTS_ASSERT_NEXT(a_credit_release, pop && !gen_acc, cnt == 4'($past(cnt) - 4'd1))

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the tone sequencer sample generator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsts_pkg::*;

  // Number of random items after the directed opening.
  localparam int RANDOM_ITEMS = 1950;
  // Hard stop for the run, well above the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  // Length of the long receiver hold that backs the block up.
  localparam int LONG_HOLD    = 120;
  // Cycles to watch the output after the last expected sample has come.
  localparam int TAIL_CYCLES  = 12;

  // Scoreboard: keeps its own copy of the note table, predicts one sample for
  // every accepted generate item and checks the samples in arrival order.
  class sample_scoreboard;
    logic [FREQ_W-1:0]         tune_table [NOTE_SLOTS];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int errors;
    int checked;

    function new();
      logic [FREQ_W-1:0] power_on [16];
      power_on = '{16'd262, 16'd330, 16'd392, 16'd523, 16'd440, 16'd349, 16'd392, 16'd294,
                   16'd330, 16'd494, 16'd392, 16'd262, 16'd294, 16'd349, 16'd440, 16'd0};
      for (int i = 0; i < NOTE_SLOTS; i++) begin
        tune_table[i] = (i < 16) ? power_on[i] : '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    // Piecewise-linear triangle over one phase period of 32000.
    function int triangle_level(int unsigned phase);
      int unsigned rise;
      if (phase < QUARTER) begin
        rise = (phase * 18000) / QUARTER;
        return -PEAK + int'(rise);
      end
      if (phase < HALF) begin
        rise = ((phase - QUARTER) * 18000) / QUARTER;
        return PEAK - int'(rise);
      end
      if (phase < THREE_Q) begin
        rise = ((phase - HALF) * 18000) / QUARTER;
        return -PEAK + int'(rise);
      end
      rise = ((phase - THREE_Q) * 18000) / QUARTER;
      return PEAK - int'(rise);
    endfunction

    function logic signed [SAMPLE_W-1:0] predict_sample(logic [31:0] frame);
      int unsigned slot;
      int unsigned pos;
      int unsigned freq;
      int unsigned env;
      int level;
      int scaled;
      slot = (frame / NOTE_LEN) % NOTE_SLOTS;
      pos  = frame % NOTE_LEN;
      freq = tune_table[slot];
      if (freq == 0) begin
        return '0;
      end
      level = triangle_level((pos * freq) % PHASE_SPAN);
      if (pos < ENV_FULL) begin
        env = pos;
      end else if (pos > REL_START) begin
        env = NOTE_LEN - 1 - pos;
      end else begin
        env = ENV_FULL;
      end
      // Signed int division truncates toward zero.
      scaled = (level * int'(env)) / ENV_FULL;
      return scaled[SAMPLE_W-1:0];
    endfunction

    function void note_item(logic act, logic [31:0] frame, logic [3:0] slot,
                            logic [FREQ_W-1:0] freq);
      if (act == ACT_WRITE) begin
        if (slot < NOTE_SLOTS) begin
          tune_table[slot] = freq;
        end
      end else begin
        expected_samples.push_back(predict_sample(frame));
      end
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] actual);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample_value: unexpected result, none expected, actual %0d", actual);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (actual !== want) begin
        $error("sample_value mismatch: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        action = ACT_GENERATE;
  logic [31:0]                 frame_number = '0;
  logic [3:0]                  note_slot = '0;
  logic [FREQ_W-1:0]           note_frequency = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_value;

  sample_scoreboard sb = new();

  // While set, neither side inserts idle cycles.
  bit no_idle = 1'b0;
  // The stimulus bumps this to ask the receiver for one long hold.
  int hold_requests = 0;
  int generates_sent = 0;
  int writes_sent = 0;
  int cycle_count = 0;

  note_sequence_triangle_synth_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .frame_number   (frame_number),
    .note_slot      (note_slot),
    .note_frequency (note_frequency),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_value   (sample_value)
  );

  always #4 clk = ~clk;

  // The run is cut off if it takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver. Samples are checked at the edge where out_valid and out_ready
  // are both high. After each sample the receiver draws a random stall, and on
  // request it holds off for a long stretch so that the result queue fills and
  // the block drops in_ready.
  int rx_wait = 0;
  int rx_hold = 0;
  int holds_served = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_sample(sample_value);
        rx_wait = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item after a random gap and returns at the edge where it was
  // accepted. Valid stays high with a steady payload until then. The task is
  // always entered at a rising edge.
  task automatic send_item(input logic act, input logic [31:0] frame,
                           input logic [3:0] slot, input logic [FREQ_W-1:0] freq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    frame_number   <= frame;
    note_slot      <= slot;
    note_frequency <= freq;
    do @(posedge clk); while (!in_ready);
    sb.note_item(act, frame, slot, freq);
    if (act == ACT_WRITE) begin
      writes_sent++;
    end else begin
      generates_sent++;
    end
  endtask

  // Generate items carry random values in the fields they do not use.
  task automatic send_generate(input logic [31:0] frame);
    send_item(ACT_GENERATE, frame, 4'($urandom), FREQ_W'($urandom));
  endtask

  task automatic send_write(input logic [3:0] slot, input logic [FREQ_W-1:0] freq);
    send_item(ACT_WRITE, $urandom, slot, freq);
  endtask

  // Stops offering items until every expected sample has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned start_pos [16];
    int unsigned pos;
    int unsigned note_idx;
    logic [31:0] frame;
    logic [FREQ_W-1:0] freq;

    start_pos = '{0, 1, 255, 256, 4000, 7743, 7744, 7998,
                  7999, 1234, 5000, 100, 6000, 7500, 2000, 3000};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. First every slot of the power-on tune is played once,
    // the last of them being the rest, at positions that hit both edges of
    // the attack and release ramps and the flat middle of the envelope.
    for (int s = 0; s < 16; s++) begin
      send_generate(32'(s * NOTE_LEN) + start_pos[s]);
    end
    // The largest frame number.
    send_generate(32'hFFFF_FFFF);
    // A frequency of 4 puts these positions on the quarter breakpoints.
    send_write(4'd0, 16'd4);
    send_generate(32'd2000);
    send_generate(32'd4000);
    send_generate(32'd6000);
    // The largest frequency, read back at the last frame of its note.
    send_write(4'd3, 16'hFFFF);
    send_generate(32'(3 * NOTE_LEN + 7999));
    // A slot rewritten to a rest.
    send_write(4'd5, 16'd0);
    send_generate(32'(5 * NOTE_LEN + 500));
    drain_results();

    // Random part. Every fourth stretch of 150 items runs with no idling on
    // either side; the long receiver hold falls inside the first of them.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i / 150) % 4 == 1);
      if (i == 160) begin
        hold_requests++;
      end
      if (i % 500 == 499) begin
        drain_results();
      end
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 3))
          0: freq = '0;
          1: freq = '1;
          2: freq = FREQ_W'($urandom_range(1, 2000));
          default: freq = FREQ_W'($urandom);
        endcase
        send_write(4'($urandom), freq);
      end else begin
        // Two of the four frame choices sit near the ends of a note, where the envelope moves.
        note_idx = $urandom_range(0, 536868);
        case ($urandom_range(0, 3))
          0: frame = $urandom;
          1: frame = note_idx * NOTE_LEN + $urandom_range(0, 300);
          2: frame = note_idx * NOTE_LEN + $urandom_range(7700, 7999);
          default: begin
            pos   = $urandom_range(0, 7999);
            frame = note_idx * NOTE_LEN + pos;
          end
        endcase
        send_generate(frame);
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d generate and %0d write items; %0d samples were compared.",
             generates_sent, writes_sent, sb.checked);
    $display("It included the power-on tune, ramp edges, breakpoints and a long output stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
